>>> rtl/edd_pkg.sv
// Shared types, constants and helpers for the 16-level error-diffusion ditherer.
// No dependencies.
`default_nettype none

package edd_pkg;

  localparam int PIX_W        = 8;
  localparam int ERR_W        = 8;
  localparam int COLS_W       = 11;
  localparam int ROWS_W       = 16;
  localparam int CFG_W        = 16;
  localparam int MAX_COLS_DEF = 1024;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(1024);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1);

  // register indexes on the config port
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // diffusion weights, in 1/16
  localparam logic [4:0] W_INT_RIGHT  = 5'd7;
  localparam logic [4:0] W_INT_BL     = 5'd3;
  localparam logic [4:0] W_INT_BELOW  = 5'd5;
  localparam logic [4:0] W_FST_RIGHT  = 5'd8;
  localparam logic [4:0] W_FST_BELOW  = 5'd6;
  localparam logic [4:0] W_FST_BR     = 5'd2;
  localparam logic [4:0] W_LST_BL     = 5'd6;
  localparam logic [4:0] W_LST_BELOW  = 5'd10;
  localparam logic [4:0] W_LAST_ROW   = 5'd16;

  // position flags of a pixel in flight
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
    logic frame_end;
  } edd_tag_t;

  // remainder times weight; fits 8 bits for every weight used
  function automatic logic [ERR_W-1:0] wmul(input logic [3:0] e, input logic [4:0] w);
    logic [8:0] p;
    p = 9'(e) * 9'(w);
    return p[ERR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/edd_line_buf.sv
// Next-row error line buffer: one write port, one registered read port.
// Same-address read and write in one cycle returns the new data. Uses edd_pkg.
`default_nettype none

module edd_line_buf #(
  parameter int MAX_COLS = edd_pkg::MAX_COLS_DEF,
  parameter int AW       = $clog2(MAX_COLS)
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [edd_pkg::ERR_W-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [edd_pkg::ERR_W-1:0] wr_data
);
  import edd_pkg::*;

  logic [ERR_W-1:0] mem [MAX_COLS];
  logic [ERR_W-1:0] mem_q;
  logic [ERR_W-1:0] byp_data;
  logic             byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp_hit  <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : mem_q;

endmodule

`default_nettype wire

>>> rtl/edd_front.sv
// Raster position tracking, line buffer read issue and the pixel stage register.
// Uses edd_pkg.
`default_nettype none

module edd_front #(
  parameter int MAX_COLS = edd_pkg::MAX_COLS_DEF,
  parameter int AW       = $clog2(MAX_COLS)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic                      move,
  input  wire logic [edd_pkg::PIX_W-1:0]  pixel_in,
  input  wire logic [edd_pkg::COLS_W-1:0] columns,
  input  wire logic [edd_pkg::ROWS_W-1:0] rows,
  output logic                           s1_valid,
  output logic      [edd_pkg::PIX_W-1:0]  s1_pixel,
  output edd_pkg::edd_tag_t              s1_tag,
  output logic      [AW-1:0]             s1_col,
  output logic                           rd_en,
  output logic      [AW-1:0]             rd_addr
);
  import edd_pkg::*;

  localparam int EW    = $clog2(MAX_COLS + 1);
  localparam int CMP_W = (EW > COLS_W) ? EW : COLS_W;
  localparam logic [CMP_W-1:0] MAXC = CMP_W'(MAX_COLS);

  logic [AW-1:0]     col_idx;
  logic [ROWS_W-1:0] row_idx;
  logic [CMP_W-1:0]  cols_x;
  logic [CMP_W-1:0]  eff_cols;
  logic [CMP_W-1:0]  col_plus1;
  logic [ROWS_W-1:0] eff_rows;
  edd_tag_t          tag;

  always_comb begin
    cols_x = CMP_W'(columns);
    if (cols_x < CMP_W'(2)) begin
      eff_cols = CMP_W'(2);
    end else if (cols_x > MAXC) begin
      eff_cols = MAXC;
    end else begin
      eff_cols = cols_x;
    end
    eff_rows      = (rows == '0) ? ROWS_W'(1) : rows;
    col_plus1     = CMP_W'(col_idx) + CMP_W'(1);
    tag.first_col = (col_idx == '0);
    tag.last_col  = (col_plus1 >= eff_cols);
    tag.first_row = (row_idx == '0);
    tag.last_row  = ({1'b0, row_idx} + 17'd1) >= {1'b0, eff_rows};
    tag.frame_end = tag.last_col && tag.last_row;
  end

  assign rd_en   = accept;
  assign rd_addr = col_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      row_idx  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (tag.last_col) begin
          col_idx <= '0;
          row_idx <= tag.frame_end ? '0 : row_idx + ROWS_W'(1);
        end else begin
          col_idx <= col_idx + AW'(1);
        end
      end else if (move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_in;
      s1_tag   <= tag;
      s1_col   <= col_idx;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edd_diffuse.sv
// Error add, saturate, quantize, and spread of the remainder to the neighbors.
// Holds the carry registers and drives the line buffer write port. Uses edd_pkg.
`default_nettype none

module edd_diffuse #(
  parameter int MAX_COLS = edd_pkg::MAX_COLS_DEF,
  parameter int AW       = $clog2(MAX_COLS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     move,
  input  wire logic [edd_pkg::PIX_W-1:0] s1_pixel,
  input  wire edd_pkg::edd_tag_t        s1_tag,
  input  wire logic [AW-1:0]            s1_col,
  input  wire logic [edd_pkg::ERR_W-1:0] below_raw,
  output logic      [edd_pkg::PIX_W-1:0] quant,
  output logic                          wr_en,
  output logic      [AW-1:0]            wr_addr,
  output logic      [edd_pkg::ERR_W-1:0] wr_data
);
  import edd_pkg::*;

  logic [ERR_W-1:0] right_carry;
  logic [ERR_W-1:0] pb0;
  logic [ERR_W-1:0] pb1;
  logic             pend_valid;
  logic [AW-1:0]    pend_addr;
  logic [ERR_W-1:0] pend_data;

  logic [ERR_W-1:0] below;
  logic [ERR_W-1:0] right;
  logic [12:0]      acc;
  logic [8:0]       val9;
  logic [7:0]       value;
  logic [3:0]       e;
  logic             mv_wr;
  logic [ERR_W-1:0] mv_data;

  always_comb begin
    below = s1_tag.first_row ? '0 : below_raw;
    right = s1_tag.first_col ? '0 : right_carry;
    acc   = {1'b0, s1_pixel, 4'b0000} + 13'(below) + 13'(right);
    val9  = acc[12:4];
    value = val9[8] ? 8'hFF : val9[7:0];
    quant = {value[7:4], 4'b0000};
    e     = value[3:0];
    // below-left write, interior and last column of a non-final row
    mv_wr   = move && !s1_tag.last_row && !s1_tag.first_col;
    mv_data = s1_tag.last_col ? pb0 + wmul(e, W_LST_BL) : pb0 + wmul(e, W_INT_BL);
    // deferred below write of the last column owns the port when present
    wr_en   = pend_valid || mv_wr;
    wr_addr = pend_valid ? pend_addr : s1_col - AW'(1);
    wr_data = pend_valid ? pend_data : mv_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      pb0         <= '0;
      pb1         <= '0;
      pend_valid  <= 1'b0;
    end else begin
      pend_valid <= move && !s1_tag.last_row && s1_tag.last_col;
      if (move) begin
        if (s1_tag.last_col) begin
          right_carry <= '0;
          pb0         <= '0;
          pb1         <= '0;
        end else if (s1_tag.last_row) begin
          right_carry <= wmul(e, W_LAST_ROW);
        end else if (s1_tag.first_col) begin
          right_carry <= wmul(e, W_FST_RIGHT);
          pb0         <= wmul(e, W_FST_BELOW);
          pb1         <= wmul(e, W_FST_BR);
        end else begin
          right_carry <= wmul(e, W_INT_RIGHT);
          pb0         <= pb1 + wmul(e, W_INT_BELOW);
          pb1         <= ERR_W'(e);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      pend_addr <= s1_col;
      pend_data <= (s1_tag.first_col ? '0 : pb1) + wmul(e, W_LST_BELOW);
    end
  end

endmodule

`default_nettype wire

>>> rtl/error_diffusion_dither_16level.sv
// Top level of the 16-level error-diffusion ditherer: config registers,
// handshake, output register. Uses edd_pkg, edd_front, edd_diffuse, edd_line_buf.
`default_nettype none

// Channel   Signals                          Direction  Transfer when
// -------   ------------------------------   ---------  ------------------
// input     in_valid, in_stall, pixel_in     in / out   in_valid & !in_stall
// output    out_valid, out_stall, pixel_out, out / in   out_valid & !out_stall
//           frame_end
// config    cfg_valid, cfg_ready, cfg_index, in / out   cfg_valid & cfg_ready
//           cfg_data
//
// One pixel per cycle sustained while the output is not stalled; a pixel passes from
// its input transfer through the pixel stage register and then the output register.
// The line buffer (one read, one write port) is read at the transfer in, and the
// error math runs on the pixel stage register and loads the output register.
// Reset: position at frame start, carries cleared; the first row ignores the
// line buffer, so no clearing pass is needed. Output stall holds the output
// register, then the pixel stage, then stalls the input.

module error_diffusion_dither_16level #(
  parameter int MAX_COLS = edd_pkg::MAX_COLS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [edd_pkg::PIX_W-1:0]  pixel_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [edd_pkg::PIX_W-1:0]  pixel_out,
  output logic                           frame_end,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [edd_pkg::CFG_W-1:0]  cfg_data
);
  import edd_pkg::*;

  localparam int AW = $clog2(MAX_COLS);

  logic [COLS_W-1:0] columns;
  logic [ROWS_W-1:0] rows;

  logic              accept;
  logic              move;
  logic              out_free;
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  edd_tag_t          s1_tag;
  logic [AW-1:0]     s1_col;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ERR_W-1:0]  rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ERR_W-1:0]  wr_data;
  logic [PIX_W-1:0]  quant;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMNS: columns <= cfg_data[COLS_W-1:0];
        CFG_ROWS:    rows    <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register frees up when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign move     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  edd_front #(.MAX_COLS(MAX_COLS), .AW(AW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .move     (move),
    .pixel_in (pixel_in),
    .columns  (columns),
    .rows     (rows),
    .s1_valid (s1_valid),
    .s1_pixel (s1_pixel),
    .s1_tag   (s1_tag),
    .s1_col   (s1_col),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  edd_line_buf #(.MAX_COLS(MAX_COLS), .AW(AW)) u_line_buf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  edd_diffuse #(.MAX_COLS(MAX_COLS), .AW(AW)) u_diffuse (
    .clk       (clk),
    .rst       (rst),
    .move      (move),
    .s1_pixel  (s1_pixel),
    .s1_tag    (s1_tag),
    .s1_col    (s1_col),
    .below_raw (rd_data),
    .quant     (quant),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      pixel_out <= quant;
      frame_end <= s1_tag.frame_end;
    end
  end

endmodule

`default_nettype wire
